>>> design/assert_macros.svh
// Assertion shorthands shared by the fastq_read_stats RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define FQS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define FQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/fqs_pkg.sv
// Shared types, constants and helper functions for fastq_read_stats.
// No dependencies; imported by every module of the block.
package fqs_pkg;

  localparam int unsigned DIV_W    = 64;
  localparam int unsigned QSUM_W   = 48;
  localparam int unsigned OUT_CNT_W = 48;
  localparam int unsigned OUT_LEN_W = 32;
  localparam int unsigned OUT_Q_W   = 8;

  localparam logic [7:0] QUAL_BASE = 8'd33;
  localparam logic [7:0] NEWLINE   = 8'd10;
  localparam logic [1:0] PHASE_SEQ  = 2'd1;
  localparam logic [1:0] PHASE_QUAL = 2'd3;   // last line of a four-line record

  localparam logic [63:0] OUT48_MAX = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] OUT32_MAX = 64'hFFFF_FFFF;
  localparam logic [63:0] OUT8_MAX  = 64'hFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REC_DIV,
    ST_LEN_DIV,
    ST_QUAL_DIV
  } fqs_state_e;

  typedef enum logic [1:0] {
    DSEL_REC,
    DSEL_LEN,
    DSEL_QUAL
  } fqs_div_sel_e;

  typedef struct packed {
    logic         byte_en;      // apply an accepted data byte
    logic         div_start;    // launch the divider
    fqs_div_sel_e div_sel;      // operand select for the launch
    logic         rec_add;      // fold per-read mean into quality total
    logic         len_cap;      // capture average length
    logic         load_result;  // fill output register and clear stats
  } fqs_cmd_t;

  typedef struct packed {
    logic rec_div_need;  // current byte ends a record that needs a mean
    logic div_done;
    logic div_busy;
    logic out_busy;
  } fqs_status_t;

  function automatic logic is_space(logic [7:0] b);
    return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  function automatic logic [OUT_CNT_W-1:0] sat_to48(logic [63:0] v);
    return (v > OUT48_MAX) ? '1 : v[OUT_CNT_W-1:0];
  endfunction

  function automatic logic [OUT_LEN_W-1:0] sat_to32(logic [63:0] v);
    return (v > OUT32_MAX) ? '1 : v[OUT_LEN_W-1:0];
  endfunction

  function automatic logic [OUT_Q_W-1:0] sat_to8(logic [63:0] v);
    return (v > OUT8_MAX) ? '1 : v[OUT_Q_W-1:0];
  endfunction

endpackage

>>> design/fqs_div.sv
// Radix-2 restoring divider with round-half-up of the quotient.
// Depends on fqs_pkg; used by fqs_datapath.
module fqs_div
  import fqs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [DIV_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] den_q;
  logic [DIV_W-1:0] res_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  logic [DIV_W:0]   rem_sh, rem_sub;
  logic             ge;
  logic             round_up;

  assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_d   = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
  assign quo_d   = {quo_q[DIV_W-2:0], ge};
  // 2*r >= d
  assign round_up = {rem_q, 1'b0} >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DIV_W);
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end else begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q && (cnt_q != '0)) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end else if (busy_q) begin
      res_q <= (den_q == '0) ? '0 : (quo_q + DIV_W'(round_up));
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = res_q;

endmodule

>>> design/fqs_ctrl.sv
// Sequencing FSM: byte acceptance, record-end and report divisions.
// Depends on fqs_pkg; drives fqs_datapath through fqs_cmd_t.
module fqs_ctrl
  import fqs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        command_i,
  output logic        in_stall_o,
  input  fqs_status_t status_i,
  output fqs_cmd_t    cmd_o
);

  fqs_state_e state_q, state_d;
  logic       accept;

  // A report waits while the previous result is still held.
  assign in_stall_o = (state_q != ST_IDLE) || (command_i && status_i.out_busy);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && command_i) begin
          state_d = ST_LEN_DIV;
        end else if (accept && status_i.rec_div_need) begin
          state_d = ST_REC_DIV;
        end
      end
      ST_REC_DIV:  if (status_i.div_done) state_d = ST_IDLE;
      ST_LEN_DIV:  if (status_i.div_done) state_d = ST_QUAL_DIV;
      ST_QUAL_DIV: if (status_i.div_done) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.div_sel = DSEL_REC;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.byte_en   = accept && !command_i;
        cmd_o.div_start = accept && (command_i || status_i.rec_div_need);
        cmd_o.div_sel   = command_i ? DSEL_LEN : DSEL_REC;
      end
      ST_REC_DIV: begin
        cmd_o.rec_add = status_i.div_done;
      end
      ST_LEN_DIV: begin
        cmd_o.len_cap   = status_i.div_done;
        cmd_o.div_start = status_i.div_done;
        cmd_o.div_sel   = DSEL_QUAL;
      end
      ST_QUAL_DIV: begin
        cmd_o.load_result = status_i.div_done;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/fqs_datapath.sv
// Per-read counters, run statistics, divider and result register.
// Depends on fqs_pkg and fqs_div; steered by fqs_ctrl.
module fqs_datapath
  import fqs_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32,
  parameter int unsigned COUNT_BITS  = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fqs_cmd_t             cmd_i,
  output fqs_status_t          status_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OUT_CNT_W-1:0] record_count_o,
  output logic [OUT_LEN_W-1:0] min_length_o,
  output logic [OUT_LEN_W-1:0] max_length_o,
  output logic [OUT_LEN_W-1:0] avg_length_o,
  output logic [OUT_Q_W-1:0]   avg_quality_o,
  output logic                 length_seen_o,
  output logic                 empty_file_o
);

  logic                     qen_q;
  logic [1:0]               phase_q, phase_d;
  logic [LENGTH_BITS-1:0]   len_q, len_d;
  logic signed [QSUM_W-1:0] qsum_q, qsum_d;
  logic [COUNT_BITS-1:0]    cnt_q, cnt_d;
  logic [LENGTH_BITS-1:0]   short_q, short_d;
  logic [LENGTH_BITS-1:0]   long_q, long_d;
  logic [63:0]              ltot_q, ltot_d;
  logic [63:0]              qtot_q, qtot_d;
  logic                     any_q, any_d;
  logic [OUT_LEN_W-1:0]     avg_len_q;
  logic                     out_valid_q;

  logic                     is_nl, is_sp, len_nz, qsum_pos;
  logic signed [8:0]        qterm;
  logic signed [QSUM_W:0]   qsum_ext;
  logic [64:0]              ltot_sum, qtot_sum;
  logic [DIV_W-1:0]         div_num, div_den, quot;
  logic                     div_busy, div_done;

  assign is_nl    = data_byte_i == NEWLINE;
  assign is_sp    = is_space(data_byte_i);
  assign len_nz   = len_q != '0;
  assign qsum_pos = !qsum_q[QSUM_W-1] && (qsum_q != '0);

  assign qterm    = $signed({1'b0, data_byte_i}) - $signed({1'b0, QUAL_BASE});
  assign qsum_ext = (QSUM_W+1)'(qsum_q) + (QSUM_W+1)'(qterm);
  assign ltot_sum = {1'b0, ltot_q} + 65'(len_q);
  assign qtot_sum = {1'b0, qtot_q} + {1'b0, quot};

  always_comb begin
    case (cmd_i.div_sel)
      DSEL_LEN: begin
        div_num = ltot_q;
        div_den = DIV_W'(cnt_q);
      end
      DSEL_QUAL: begin
        div_num = qtot_q;
        div_den = DIV_W'(cnt_q);
      end
      default: begin
        div_num = DIV_W'(unsigned'(qsum_q));
        div_den = DIV_W'(len_q);
      end
    endcase
  end

  fqs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    qsum_d  = qsum_q;
    cnt_d   = cnt_q;
    short_d = short_q;
    long_d  = long_q;
    ltot_d  = ltot_q;
    qtot_d  = qtot_q;
    any_d   = any_q;

    if (cmd_i.load_result) begin
      phase_d = '0;
      len_d   = '0;
      qsum_d  = '0;
      cnt_d   = '0;
      short_d = '1;
      long_d  = '0;
      ltot_d  = '0;
      qtot_d  = '0;
      any_d   = 1'b0;
    end else if (cmd_i.rec_add) begin
      qtot_d = qtot_sum[64] ? '1 : qtot_sum[63:0];
    end else if (cmd_i.byte_en) begin
      if (is_nl) begin
        if (phase_q == PHASE_QUAL) begin
          if (len_nz) begin
            if (len_q > long_q)  long_d  = len_q;
            if (len_q < short_q) short_d = len_q;
            ltot_d = ltot_sum[64] ? '1 : ltot_sum[63:0];
            any_d  = 1'b1;
          end
          if (cnt_q != '1) cnt_d = cnt_q + 1'b1;
          qsum_d  = '0;
          len_d   = '0;
          phase_d = '0;
        end else begin
          phase_d = phase_q + 2'd1;
        end
      end else if ((phase_q == PHASE_SEQ) && !is_sp) begin
        if (len_q != '1) len_d = len_q + 1'b1;
      end else if ((phase_q == PHASE_QUAL) && qen_q && !is_sp) begin
        // clamp to the signed 48-bit range
        if (qsum_ext[QSUM_W] != qsum_ext[QSUM_W-1]) begin
          qsum_d = qsum_ext[QSUM_W] ? {1'b1, {(QSUM_W-1){1'b0}}}
                                    : {1'b0, {(QSUM_W-1){1'b1}}};
        end else begin
          qsum_d = qsum_ext[QSUM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qen_q       <= 1'b0;
      phase_q     <= '0;
      len_q       <= '0;
      qsum_q      <= '0;
      cnt_q       <= '0;
      short_q     <= '1;
      long_q      <= '0;
      ltot_q      <= '0;
      qtot_q      <= '0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) qen_q <= cfg_wdata_i;
      phase_q <= phase_d;
      len_q   <= len_d;
      qsum_q  <= qsum_d;
      cnt_q   <= cnt_d;
      short_q <= short_d;
      long_q  <= long_d;
      ltot_q  <= ltot_d;
      qtot_q  <= qtot_d;
      any_q   <= any_d;
      if (cmd_i.load_result) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.len_cap) avg_len_q <= sat_to32(quot);
    if (cmd_i.load_result) begin
      record_count_o <= sat_to48(64'(cnt_q));
      min_length_o   <= any_q ? sat_to32(64'(short_q)) : '0;
      max_length_o   <= sat_to32(64'(long_q));
      avg_length_o   <= avg_len_q;
      avg_quality_o  <= qen_q ? sat_to8(quot) : '0;
      length_seen_o  <= any_q;
      empty_file_o   <= cnt_q == '0;
    end
  end

  assign out_valid_o = out_valid_q;

  assign status_o.rec_div_need = is_nl && (phase_q == PHASE_QUAL) && qen_q
                                 && qsum_pos && len_nz;
  assign status_o.div_done     = div_done;
  assign status_o.div_busy     = div_busy;
  assign status_o.out_busy     = out_valid_q;

endmodule

>>> design/fastq_read_stats_unit.sv
// FASTQ read length / quality statistics unit, top level.
// Depends on fqs_pkg, fqs_ctrl, fqs_datapath (with fqs_div) and assert_macros.svh.
//
// Takes a decompressed FASTQ stream one byte per transfer and keeps running
// statistics over four-line records: record count, shortest and longest
// non-zero read, total length and, with quality_enable set, the sum of the
// rounded per-read mean qualities (byte minus 33 over the quality line).
// A transfer with command set is the end-of-file report: one result transfer
// carries count, min, max and the half-up rounded average length and quality,
// and all statistics clear (a trailing partial record is dropped).
// Sequencing: data bytes are taken while idle. A byte that closes a record
// with quality_enable set, a positive quality sum and non-zero length also
// runs one per-read division through the shared 64-bit radix-2 divider
// (load, 64 steps, finish, fold) and holds off further bytes until it is folded.
// A report runs two divisions back to back; the result enters the output
// register as the second finishes and byte transfers resume as it appears;
// a further report waits until that result has been taken. quality_enable
// must be written only while the unit is idle; the unit does not enforce it.

`include "assert_macros.svh"

module fastq_read_stats_unit
  import fqs_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32,
  parameter int unsigned COUNT_BITS  = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 command_i,
  input  logic [7:0]           data_byte_i,
  // configuration
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OUT_CNT_W-1:0] record_count_o,
  output logic [OUT_LEN_W-1:0] min_length_o,
  output logic [OUT_LEN_W-1:0] max_length_o,
  output logic [OUT_LEN_W-1:0] avg_length_o,
  output logic [OUT_Q_W-1:0]   avg_quality_o,
  output logic                 length_seen_o,
  output logic                 empty_file_o
);

  fqs_cmd_t    cmd;
  fqs_status_t status;

  // Controller: decides when a byte lands and sequences the divisions.
  fqs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .command_i (command_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Datapath: counters, accumulators, divider and the result register.
  fqs_datapath #(
    .LENGTH_BITS(LENGTH_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .data_byte_i   (data_byte_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .record_count_o(record_count_o),
    .min_length_o  (min_length_o),
    .max_length_o  (max_length_o),
    .avg_length_o  (avg_length_o),
    .avg_quality_o (avg_quality_o),
    .length_seen_o (length_seen_o),
    .empty_file_o  (empty_file_o)
  );

  // The divider is never relaunched mid-division.
  `FQS_ASSERT_NOW(a_div_free, cmd.div_start, !status.div_busy, "divider launched while busy")
  // A new result never overwrites one still waiting.
  `FQS_ASSERT_NOW(a_out_free, cmd.load_result, !out_valid_o, "result overwritten")
  // A taken result is not shown again; the next one needs a fresh report.
  `FQS_ASSERT_NEXT(a_out_drain, out_valid_o && !out_stall_i, !out_valid_o, "result shown twice")

endmodule

>>> tb/fastq_read_stats_unit_test.sv
// Self-checking testbench for fastq_read_stats_unit: FASTQ bytes and reports
// go in, each report result is checked field by field against a local predictor.
// Depends on fqs_pkg and the fastq_read_stats_unit RTL.
`timescale 1ns / 100ps

module fastq_read_stats_unit_test
  import fqs_pkg::*;
();

  // Run limits. The hold-off covers a per-read division still in flight
  // after the last result, and the tail covers a full report.
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned HOLDOFF_CYC  = 100;
  localparam int unsigned TAIL_CYC     = 160;
  localparam int unsigned PHASE_BYTES  = 200;
  localparam int unsigned PHASE_REPS   = 3;
  localparam int unsigned NUM_PHASES   = 8;

  localparam longint QSUM_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint QSUM_LO = -QSUM_HI - 1;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] count;
    logic [OUT_LEN_W-1:0] min_len;
    logic [OUT_LEN_W-1:0] max_len;
    logic [OUT_LEN_W-1:0] avg_len;
    logic [OUT_Q_W-1:0]   avg_qual;
    logic                 seen;
    logic                 empty;
  } stats_report_t;

  // Clock and reset.
  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // DUT ports.
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 command_i;
  logic [7:0]           data_byte_i;
  logic                 cfg_we_i;
  logic                 cfg_wdata_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [OUT_CNT_W-1:0] record_count_o;
  logic [OUT_LEN_W-1:0] min_length_o;
  logic [OUT_LEN_W-1:0] max_length_o;
  logic [OUT_LEN_W-1:0] avg_length_o;
  logic [OUT_Q_W-1:0]   avg_quality_o;
  logic                 length_seen_o;
  logic                 empty_file_o;

  fastq_read_stats_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .data_byte_i    (data_byte_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .record_count_o (record_count_o),
    .min_length_o   (min_length_o),
    .max_length_o   (max_length_o),
    .avg_length_o   (avg_length_o),
    .avg_quality_o  (avg_quality_o),
    .length_seen_o  (length_seen_o),
    .empty_file_o   (empty_file_o)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of what the unit keeps between bytes.
  // ---------------------------------------------------------------------------
  logic                   qual_on;
  logic [1:0]             cur_line;      // newline count modulo four
  logic [31:0]            cur_length;    // non-space bytes on the sequence line
  longint                 cur_qsum;      // signed sum of (byte - 33), 48-bit clamp
  logic [47:0]            done_records;
  logic [31:0]            min_len;
  logic [31:0]            max_len;
  logic [63:0]            sum_len;
  logic [63:0]            sum_qual;      // sum of rounded per-read means
  logic                   saw_length;

  stats_report_t          pending_reports[$];
  int unsigned            mismatches;
  int unsigned            reports_checked;
  int unsigned            bytes_sent;
  int unsigned            cycle_count;
  int unsigned            sink_hold;
  logic                   hold_drawn;
  logic                   calm;          // no idling on either side when set

  function automatic logic is_blank(logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic [63:0] add_sat64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = a + b;
    return s[64] ? '1 : s[63:0];
  endfunction

  // Integer division, remainder of at least half the divisor rounds up.
  function automatic logic [63:0] round_div(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    if (den == 0) return '0;
    q = num / den;
    r = num % den;
    if (r >= den - r) q = q + 1;
    return q;
  endfunction

  function automatic void clear_stats();
    cur_line     = '0;
    cur_length   = '0;
    cur_qsum     = 0;
    done_records = '0;
    min_len      = '1;
    max_len      = '0;
    sum_len      = '0;
    sum_qual     = '0;
    saw_length   = 1'b0;
  endfunction

  // Fourth newline: fold the read into the running statistics.
  function automatic void close_record();
    if (cur_length != 0) begin
      if (cur_length > max_len) max_len = cur_length;
      if (cur_length < min_len) min_len = cur_length;
      sum_len    = add_sat64(sum_len, 64'(cur_length));
      saw_length = 1'b1;
    end
    // zero-length reads never add a mean, whatever the quality sum
    if (qual_on && cur_qsum > 0 && cur_length != 0)
      sum_qual = add_sat64(sum_qual, round_div(64'(cur_qsum), 64'(cur_length)));
    cur_qsum = 0;
    if (done_records != '1) done_records = done_records + 1;
    cur_length = '0;
    cur_line   = '0;
  endfunction

  function automatic void fold_byte(logic [7:0] b);
    longint s;
    if (b == NEWLINE) begin
      if (cur_line == PHASE_QUAL) close_record();
      else cur_line = cur_line + 1;
    end else if (cur_line == PHASE_SEQ && !is_blank(b)) begin
      if (cur_length != '1) cur_length = cur_length + 1;
    end else if (cur_line == PHASE_QUAL && qual_on && !is_blank(b)) begin
      s = cur_qsum + (longint'(b) - longint'(QUAL_BASE));
      if (s > QSUM_HI) s = QSUM_HI;
      if (s < QSUM_LO) s = QSUM_LO;
      cur_qsum = s;
    end
  endfunction

  // End of file: the statistics as reported, then everything clears
  // (a partial record in progress is dropped with the rest).
  function automatic stats_report_t file_report();
    stats_report_t r;
    logic [63:0]   n;
    logic [63:0]   avg;
    logic [63:0]   aq;
    n          = 64'(done_records);
    avg        = round_div(sum_len, n);
    aq         = qual_on ? round_div(sum_qual, n) : '0;
    r.count    = done_records;
    r.min_len  = saw_length ? min_len : '0;
    r.max_len  = max_len;
    r.avg_len  = (avg > 64'hFFFF_FFFF) ? '1 : avg[31:0];
    r.avg_qual = (aq > 64'hFF) ? '1 : aq[7:0];
    r.seen     = saw_length;
    r.empty    = (n == 0);
    clear_stats();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake helpers.
  // ---------------------------------------------------------------------------
  function automatic int unsigned draw_gap();
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    $display("[%0t] report %0d %s: got %0d, expected %0d",
             $realtime, reports_checked, what, got, want);
  endtask

  // Moves one item across the input channel. Called at a falling edge and
  // returns at one; valid stays up so a back-to-back item needs no reassert.
  task automatic send_transfer(input logic cmd, input logic [7:0] b);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid_i  = 1'b0;
      command_i   = 1'($urandom);
      data_byte_i = 8'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    command_i   = cmd;
    data_byte_i = b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // accepted at this edge
    if (cmd) pending_reports.push_back(file_report());
    else fold_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Lets every result come out and any per-read division finish, so the
  // unit is idle before the register changes.
  task automatic wait_idle(input int unsigned cycles);
    in_valid_i = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic write_quality_enable(input logic en);
    wait_idle(HOLDOFF_CYC);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = en;
    @(posedge clk_i);
    qual_on = en;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'($urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, then compare against the oldest expectation.
  // ---------------------------------------------------------------------------
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (out_valid_o && !hold_drawn) begin
        sink_hold  = draw_gap();
        hold_drawn = 1'b1;
      end
      if (!out_valid_o) begin
        out_stall_i = !calm && ($urandom_range(0, 3) == 0);
      end else if (sink_hold != 0) begin
        out_stall_i = 1'b1;
        sink_hold--;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    stats_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      hold_drawn = 1'b0;
      if (pending_reports.size() == 0) begin
        note_mismatch("unexpected result, record_count", 64'(record_count_o), '0);
      end else begin
        want = pending_reports.pop_front();
        if (record_count_o !== want.count)
          note_mismatch("record_count", 64'(record_count_o), 64'(want.count));
        if (min_length_o !== want.min_len)
          note_mismatch("min_length", 64'(min_length_o), 64'(want.min_len));
        if (max_length_o !== want.max_len)
          note_mismatch("max_length", 64'(max_length_o), 64'(want.max_len));
        if (avg_length_o !== want.avg_len)
          note_mismatch("avg_length", 64'(avg_length_o), 64'(want.avg_len));
        if (avg_quality_o !== want.avg_qual)
          note_mismatch("avg_quality", 64'(avg_quality_o), 64'(want.avg_qual));
        if (length_seen_o !== want.seen)
          note_mismatch("length_seen", 64'(length_seen_o), 64'(want.seen));
        if (empty_file_o !== want.empty)
          note_mismatch("empty_file", 64'(empty_file_o), 64'(want.empty));
      end
      reports_checked++;
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** fastq_read_stats_unit: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Random record content.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_base();
    case ($urandom_range(0, 4))
      0:       return "A";
      1:       return "C";
      2:       return "G";
      3:       return "T";
      default: return "N";
    endcase
  endfunction

  function automatic logic [7:0] any_but_newline();
    logic [7:0] b;
    b = 8'($urandom);
    while (b == NEWLINE) b = 8'($urandom);
    return b;
  endfunction

  // In a broken record some bytes, newlines included, are replaced by noise.
  function automatic logic [7:0] garble(logic [7:0] b, logic broken);
    return (broken && $urandom_range(0, 7) == 0) ? 8'($urandom) : b;
  endfunction

  task automatic send_record(input logic broken);
    int unsigned hdr_n;
    int unsigned seq_n;
    int unsigned qual_n;
    hdr_n = $urandom_range(0, 3);
    seq_n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 10);
    qual_n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 12) : seq_n;
    if (hdr_n != 0) send_transfer(1'b0, garble("@", broken));
    repeat (hdr_n) send_transfer(1'b0, garble(any_but_newline(), broken));
    send_transfer(1'b0, garble(NEWLINE, broken));
    repeat (seq_n)
      send_transfer(1'b0, garble(($urandom_range(0, 7) == 0) ? any_but_newline()
                                                               : pick_base(), broken));
    send_transfer(1'b0, garble(NEWLINE, broken));
    if ($urandom_range(0, 1) != 0) send_transfer(1'b0, garble("+", broken));
    send_transfer(1'b0, garble(NEWLINE, broken));
    repeat (qual_n)
      send_transfer(1'b0, garble(($urandom_range(0, 9) == 0) ? any_but_newline()
                                                               : 8'($urandom_range(33, 74)),
                                 broken));
    send_transfer(1'b0, garble(NEWLINE, broken));
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Report right after reset: nothing seen, quality off.
  task automatic test_empty_report();
    send_transfer(1'b1, 8'hFF);
    write_quality_enable(1'b1);
  endtask

  // High bytes count as sequence, tab and CR do not; top quality bytes
  // give the largest per-read mean.
  task automatic test_extreme_record();
    send_transfer(1'b0, NEWLINE);
    send_transfer(1'b0, 8'hFF);
    send_transfer(1'b0, 8'h80);
    send_transfer(1'b0, 8'h09);
    send_transfer(1'b0, 8'h0D);
    send_transfer(1'b0, NEWLINE);
    send_transfer(1'b0, NEWLINE);
    send_transfer(1'b0, 8'hFF);
    send_transfer(1'b0, 8'hFF);
    send_transfer(1'b0, NEWLINE);
  endtask

  // Zero-length read with a positive quality sum adds nothing; a negative
  // quality sum adds nothing either, but the length still counts.
  task automatic test_quality_corners();
    send_transfer(1'b0, NEWLINE);
    send_transfer(1'b0, NEWLINE);
    send_transfer(1'b0, NEWLINE);
    send_transfer(1'b0, "~");
    send_transfer(1'b0, NEWLINE);
    send_transfer(1'b0, NEWLINE);
    send_transfer(1'b0, "G");
    send_transfer(1'b0, NEWLINE);
    send_transfer(1'b0, NEWLINE);
    send_transfer(1'b0, 8'h00);
    send_transfer(1'b0, NEWLINE);
    send_transfer(1'b1, 8'h00);
  endtask

  // A record with quality, then half a record; quality goes off before the
  // report, so the average quality reads zero and the partial read is lost.
  task automatic test_partial_drop();
    send_transfer(1'b0, NEWLINE);
    send_transfer(1'b0, "A");
    send_transfer(1'b0, NEWLINE);
    send_transfer(1'b0, NEWLINE);
    send_transfer(1'b0, "J");
    send_transfer(1'b0, NEWLINE);
    send_transfer(1'b0, NEWLINE);
    send_transfer(1'b0, "C");
    write_quality_enable(1'b0);
    send_transfer(1'b1, 8'h5A);
  endtask

  // Mostly well-formed records with random content, some broken ones and
  // noise bursts, reports at random points; the register changes between
  // phases, sometimes with a record still open.
  task automatic test_random_phases();
    int unsigned ph;
    int unsigned start_bytes;
    int unsigned phase_reps;
    int unsigned roll;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      calm = (ph == 2) || (ph == 5);
      write_quality_enable((ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : 1'($urandom));
      start_bytes = bytes_sent;
      phase_reps  = 0;
      while (bytes_sent - start_bytes < PHASE_BYTES || phase_reps < PHASE_REPS) begin
        roll = $urandom_range(0, 19);
        if (roll == 0) repeat ($urandom_range(1, 6)) send_transfer(1'b0, 8'($urandom));
        else send_record(roll < 3);
        if ($urandom_range(0, 2) == 0) begin
          send_transfer(1'b1, 8'($urandom));
          phase_reps++;
        end
      end
      // leave a record half done now and then across the register write
      if ($urandom_range(0, 2) == 0) begin
        send_transfer(1'b0, NEWLINE);
        send_transfer(1'b0, pick_base());
      end
    end
    calm = 1'b0;
    send_transfer(1'b1, 8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    command_i       = 1'b0;
    data_byte_i     = 8'h00;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 1'b0;
    mismatches      = 0;
    reports_checked = 0;
    bytes_sent      = 0;
    cycle_count     = 0;
    sink_hold       = 0;
    hold_drawn      = 1'b0;
    calm            = 1'b0;
    qual_on         = 1'b0;
    clear_stats();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_report();
    test_extreme_record();
    test_quality_corners();
    test_partial_drop();
    test_random_phases();

    wait_idle(TAIL_CYC);
    if (mismatches == 0) begin
      $display("** fastq_read_stats_unit: PASSED **");
    end else begin
      $display("** fastq_read_stats_unit: FAILED **");
    end
    $finish;
  end

endmodule
